@@ rtl/vtpd_pkg.sv @@
// Shared constants and types for the vertex transform and perspective divide block.
`default_nettype none

package vtpd_pkg;

    localparam int NUM_REGS        = 8;
    localparam int REG_AW          = 3;
    localparam int PADDR_W         = 6;
    localparam int NEAR_ZERO_LIMIT = 66;
    localparam int MAG_W           = 50;
    localparam int SUM_W           = 66;
    localparam int DIV_STEPS       = 32;
    localparam int FIFO_DEPTH      = 4;
    localparam int FIFO_AW         = 2;
    localparam int ROUND_SHIFT     = 15;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;

    // one coordinate as it leaves the front end
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [MAG_W-1:0]  mag;
        logic [31:0]       pass;
    } t_qlane;

    // queue entry between front and back
    typedef struct packed {
        logic              do_div;
        logic              flag;
        logic [MAG_W-1:0]  wmag;
        t_qlane [2:0]      lane;
    } t_qent;

    // one coordinate inside the divider pipeline
    typedef struct packed {
        logic              neg;
        logic              sat;
        logic [MAG_W-1:0]  rem;
        logic [31:0]       dl;
        logic [31:0]       res;
    } t_dlane;

    typedef struct packed {
        logic              do_div;
        logic              flag;
        logic [MAG_W-1:0]  wmag;
        t_dlane [2:0]      lane;
    } t_dstage;

endpackage

`default_nettype wire

@@ rtl/vtpd_front.sv @@
// Front end: matrix registers, 4x4 multiply, rounding and divide classification.
`default_nettype none

module vtpd_front import vtpd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [63:0]        i_pwdata,
    output logic      [63:0]        o_prdata,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [127:0]       i_data,   // x, y, z, w
    input  wire logic               i_div,
    output logic                    o_push,
    output t_qent                   o_ent,
    input  wire logic               i_full
);

    localparam logic [63:0] M_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0,
        64'h0001_0000_0000_0000, 64'h0,
        64'h0,                   64'h0000_0000_0001_0000,
        64'h0,                   64'h0001_0000_0000_0000
    };

    function automatic logic [31:0] sat32(input logic signed [MAG_W-1:0] n);
        logic [31:0] r;
        if ((&n[MAG_W-1:31]) || !(|n[MAG_W-1:31])) begin
            r = n[31:0];
        end else if (n[MAG_W-1]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    logic [63:0]              r_mreg [NUM_REGS];
    logic [5:0]               r_v;
    logic                     w_en;

    logic signed [31:0]       r_vin [4];
    logic [4:0]               r_de;
    logic signed [31:0]       w_m   [4][4];
    logic signed [63:0]       r_prod [4][4];
    logic signed [SUM_W-1:0]  r_ps  [2][4];
    logic [SUM_W-1:0]         w_sum [4];
    logic signed [MAG_W-1:0]  r_n   [4];

    logic                     w_wneg;
    logic [MAG_W-1:0]         w_wabs;
    logic                     w_big;
    logic                     r_dodiv;
    logic                     r_flag;
    logic [MAG_W-1:0]         r_wmag;
    logic [2:0]               r_neg;
    logic [MAG_W-1:0]         r_mag  [3];
    logic [31:0]              r_pass [3];
    t_qent                    r_ent;

    assign w_en     = !r_v[5] || !i_full;
    assign o_ready  = w_en;
    assign o_push   = r_v[5] && !i_full;
    assign o_ent    = r_ent;
    assign o_prdata = r_mreg[i_paddr[PADDR_W-1:3]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_mreg[i] <= M_RESET[i];
            end
            r_v <= '0;
        end else begin
            if (i_psel && i_penable && i_pwrite) begin
                r_mreg[i_paddr[PADDR_W-1:3]] <= i_pwdata;
            end
            if (w_en) begin
                r_v <= {r_v[4:0], i_valid};
            end
        end
    end

    for (genvar gi = 0; gi < 4; gi++) begin : g_row
        for (genvar gc = 0; gc < 4; gc++) begin : g_col
            if (gc % 2 == 1) begin : g_odd
                assign w_m[gi][gc] = r_mreg[gi*2 + gc/2][63:32];
            end else begin : g_even
                assign w_m[gi][gc] = r_mreg[gi*2 + gc/2][31:0];
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_sum[c] = r_ps[0][c] + r_ps[1][c] + SUM_W'(32768);
        end
        w_wneg = r_n[3][MAG_W-1];
        w_wabs = w_wneg ? MAG_W'(-r_n[3]) : MAG_W'(r_n[3]);
        w_big  = w_wabs > MAG_W'(NEAR_ZERO_LIMIT);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_vin[i] <= i_data[32*i +: 32];
            end
            r_de <= {r_de[3:0], i_div};
            for (int i = 0; i < 4; i++) begin
                for (int c = 0; c < 4; c++) begin
                    r_prod[i][c] <= r_vin[i] * w_m[i][c];
                end
            end
            for (int c = 0; c < 4; c++) begin
                r_ps[0][c] <= SUM_W'(r_prod[0][c]) + SUM_W'(r_prod[1][c]);
                r_ps[1][c] <= SUM_W'(r_prod[2][c]) + SUM_W'(r_prod[3][c]);
                r_n[c]     <= w_sum[c][SUM_W-1:16];
            end
            r_dodiv <= r_de[3] && w_big;
            r_flag  <= r_de[3] && !w_big;
            r_wmag  <= w_wabs;
            for (int c = 0; c < 3; c++) begin
                r_neg[c]  <= r_n[c][MAG_W-1] ^ w_wneg;
                r_mag[c]  <= r_n[c][MAG_W-1] ? MAG_W'(-r_n[c]) : MAG_W'(r_n[c]);
                r_pass[c] <= sat32(r_n[c]);
            end
            r_ent.do_div <= r_dodiv;
            r_ent.flag   <= r_flag;
            r_ent.wmag   <= r_wmag;
            for (int c = 0; c < 3; c++) begin
                r_ent.lane[c].neg  <= r_neg[c];
                r_ent.lane[c].sat  <= {15'b0, r_mag[c]} >= {r_wmag, 15'b0};
                r_ent.lane[c].mag  <= r_mag[c];
                r_ent.lane[c].pass <= r_pass[c];
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/vtpd_fifo.sv @@
// Short queue between the front end and the divider back end.
`default_nettype none

module vtpd_fifo import vtpd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_qent i_ent,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_qent      o_ent,
    output logic       o_empty
);

    t_qent               r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]  r_wp;
    logic [FIFO_AW-1:0]  r_rp;
    logic [FIFO_AW:0]    r_cnt;

    assign o_full  = r_cnt == (FIFO_AW+1)'(FIFO_DEPTH);
    assign o_empty = r_cnt == '0;
    assign o_ent   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_ent;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH)) else $error("queue count out of range");

endmodule

`default_nettype wire

@@ rtl/vtpd_back.sv @@
// Back end: pipelined restoring divider, rounding, saturation and output register.
`default_nettype none

module vtpd_back import vtpd_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_qent i_ent,
    output logic       o_pop,
    output logic       o_tvalid,
    input  wire logic  i_tready,
    output logic [95:0] o_tdata,  // x, y, z
    output logic       o_tuser    // w_near_zero
);

    function automatic t_dstage div_step(input t_dstage s);
        t_dstage          n;
        logic [MAG_W:0]   ts;
        logic             ge;
        n = s;
        for (int c = 0; c < 3; c++) begin
            ts = {s.lane[c].rem, s.lane[c].dl[31]};
            ge = ts >= {1'b0, s.wmag};
            if (s.do_div) begin
                n.lane[c].rem = ge ? MAG_W'(ts - {1'b0, s.wmag}) : ts[MAG_W-1:0];
                n.lane[c].dl  = {s.lane[c].dl[30:0], 1'b0};
                n.lane[c].res = {s.lane[c].res[30:0], ge};
            end
        end
        return n;
    endfunction

    function automatic logic [31:0] finish(input logic do_div, input t_dlane l);
        logic [31:0] rq;
        logic [31:0] r;
        rq = {1'b0, l.res[31:1]} + {31'b0, l.res[0]};
        if (!do_div) begin
            r = l.res;
        end else if (l.sat) begin
            r = l.neg ? Q_MIN : Q_MAX;
        end else if (l.neg) begin
            r = -rq;
        end else begin
            r = rq[31] ? Q_MAX : rq;
        end
        return r;
    endfunction

    logic               w_en;
    logic [DIV_STEPS:0] r_bv;
    t_dstage            r_st [DIV_STEPS+1];
    t_dstage            w_nx [DIV_STEPS];
    t_dstage            w_ld;
    logic               r_ov;
    logic [95:0]        r_od;
    logic               r_ou;

    assign w_en     = !r_ov || i_tready;
    assign o_pop    = w_en && i_valid;
    assign o_tvalid = r_ov;
    assign o_tdata  = r_od;
    assign o_tuser  = r_ou;

    always_comb begin
        w_ld.do_div = i_ent.do_div;
        w_ld.flag   = i_ent.flag;
        w_ld.wmag   = i_ent.wmag;
        for (int c = 0; c < 3; c++) begin
            w_ld.lane[c].neg = i_ent.lane[c].neg;
            w_ld.lane[c].sat = i_ent.lane[c].sat;
            w_ld.lane[c].rem = {{ROUND_SHIFT{1'b0}}, i_ent.lane[c].mag[MAG_W-1:ROUND_SHIFT]};
            w_ld.lane[c].dl  = {i_ent.lane[c].mag[ROUND_SHIFT-1:0], 17'b0};
            w_ld.lane[c].res = i_ent.lane[c].pass;
        end
        for (int s = 0; s < DIV_STEPS; s++) begin
            w_nx[s] = div_step(r_st[s]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_bv <= {r_bv[DIV_STEPS-1:0], o_pop};
            r_ov <= r_bv[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_st[0] <= w_ld;
            for (int s = 0; s < DIV_STEPS; s++) begin
                r_st[s+1] <= w_nx[s];
            end
            for (int c = 0; c < 3; c++) begin
                r_od[32*c +: 32] <= finish(r_st[DIV_STEPS].do_div, r_st[DIV_STEPS].lane[c]);
            end
            r_ou <= r_st[DIV_STEPS].flag;
        end
    end

    a_div_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bv[0] |-> !(r_st[0].do_div && r_st[0].flag))
        else $error("divide and near-zero flag both set");

endmodule

`default_nettype wire

@@ rtl/vertex_transform_persp_divide_core.sv @@
// Top level: 4x4 Q16.16 vertex transform with optional perspective divide.
// Throughput: one beat per cycle unless downstream stalls; divider has 32 stages.
// The queue lets new beats enter while a result waits downstream, until it fills.
// Reset (synchronous, active low) empties all stages and loads the identity matrix.
`default_nettype none

module vertex_transform_persp_divide_core import vtpd_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [63:0]        i_pwdata,
    output logic      [63:0]        o_prdata,
    output logic                    o_pready,
    input  wire logic               i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  wire logic [127:0]       i_s_axis_tdata,  // x_in, y_in, z_in, w_in
    input  wire logic               i_s_axis_tuser,  // divide_enable
    output logic                    o_m_axis_tvalid,
    input  wire logic               i_m_axis_tready,
    output logic [95:0]             o_m_axis_tdata,  // x_out, y_out, z_out
    output logic                    o_m_axis_tuser   // w_near_zero
);

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_empty;
    t_qent w_fent;
    t_qent w_bent;

    assign o_pready = 1'b1;

    vtpd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_div     (i_s_axis_tuser),
        .o_push    (w_push),
        .o_ent     (w_fent),
        .i_full    (w_full)
    );

    vtpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_ent   (w_fent),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_ent   (w_bent),
        .o_empty (w_empty)
    );

    vtpd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!w_empty),
        .i_ent    (w_bent),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (o_m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Testbench for the vertex transform and perspective divide core.
`timescale 1ns / 100ps

module tb_top;
    import vtpd_pkg::*;

    typedef struct {
        logic signed [31:0] x, y, z, w;
        logic               dv;
    } vtx_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        nz;
    } xf_t;

    localparam int WDOG_LIMIT = 4000;
    localparam int N_RAND     = 700;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_psel = 1'b0;
    logic         i_penable = 1'b0;
    logic         i_pwrite = 1'b0;
    logic [PADDR_W-1:0] i_paddr = '0;
    logic [63:0]  i_pwdata = '0;
    logic [63:0]  o_prdata;
    logic         o_pready;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;  // x_in, y_in, z_in, w_in
    logic         i_s_axis_tuser = 1'b0; // divide_enable
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [95:0]  o_m_axis_tdata;       // x_out, y_out, z_out
    logic         o_m_axis_tuser;       // w_near_zero

    vertex_transform_persp_divide_core dut (.*);

    always #1 i_clk = ~i_clk;

    logic [63:0] mat_regs [NUM_REGS];
    vtx_t  pending_vtx[$];
    xf_t   expected_xf[$];
    int    n_mismatch = 0;
    int    wdog = 0;
    bit    driver_on = 1'b0;
    bit    timed_out = 1'b0;

    function automatic logic signed [63:0] mat_at(int r, int c);
        logic [63:0] rv;
        rv = mat_regs[r*2 + c/2];
        return (c % 2) ? 64'(signed'(rv[63:32])) : 64'(signed'(rv[31:0]));
    endfunction

    // exact sum of Q32.32 products, rounded half up to Q16.16
    function automatic logic signed [71:0] column_dot(vtx_t v, int c);
        logic signed [71:0] acc;
        logic signed [71:0] comp [4];
        comp[0] = 72'(v.x); comp[1] = 72'(v.y); comp[2] = 72'(v.z); comp[3] = 72'(v.w);
        acc = 0;
        for (int i = 0; i < 4; i++) acc += comp[i] * 72'(mat_at(i, c));
        return (acc + 72'sd32768) >>> 16;
    endfunction

    function automatic logic [31:0] clamp32(logic signed [71:0] v);
        if (v > 72'sd2147483647) return Q_MAX;
        if (v < -72'sd2147483648) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic logic [31:0] persp_div(logic signed [71:0] n, logic [71:0] wm,
                                              bit wneg);
        logic [71:0] mag, q, r;
        bit neg;
        neg = (n < 0) != wneg;
        mag = (n < 0) ? 72'(-n) : 72'(n);
        q = mag / wm;
        if (q >= 32768) return neg ? Q_MIN : Q_MAX;
        q = (mag << 16) / wm;
        r = (mag << 16) % wm;
        if ((r << 1) >= wm) q += 1;
        if (neg) return clamp32(-$signed(q));
        return clamp32($signed(q));
    endfunction

    function automatic xf_t transform_vertex(vtx_t v);
        xf_t o;
        logic signed [71:0] s [3];
        logic signed [71:0] wv;
        logic [71:0] wm;
        for (int c = 0; c < 3; c++) s[c] = column_dot(v, c);
        o.nz = 1'b0;
        if (v.dv) begin
            wv = column_dot(v, 3);
            wm = (wv < 0) ? 72'(-wv) : 72'(wv);
            if (wm > NEAR_ZERO_LIMIT) begin
                o.x = persp_div(s[0], wm, wv < 0);
                o.y = persp_div(s[1], wm, wv < 0);
                o.z = persp_div(s[2], wm, wv < 0);
                return o;
            end
            o.nz = 1'b1;
        end
        o.x = clamp32(s[0]); o.y = clamp32(s[1]); o.z = clamp32(s[2]);
        return o;
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        vtx_t v;
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            expected_xf.push_back(transform_vertex(pending_vtx.pop_front()));
            src_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        end
        if (src_gap > 0) src_gap--;
        if (driver_on && pending_vtx.size() > 0 && (src_gap == 0 ||
                (i_s_axis_tvalid && !o_s_axis_tready))) begin
            v = pending_vtx[0];
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata  <= {v.w, v.z, v.y, v.x};
            i_s_axis_tuser  <= v.dv;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    int snk_gap = 0;
    always @(posedge i_clk) begin
        xf_t e;
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                wdog = 0;
            else if (expected_xf.size() > 0 || pending_vtx.size() > 0)
                wdog++;
            if (wdog >= WDOG_LIMIT) timed_out = 1'b1;
        end
        if (o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_xf.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected beat %h", o_m_axis_tdata);
            end else begin
                e = expected_xf.pop_front();
                if ({e.z, e.y, e.x} !== o_m_axis_tdata || e.nz !== o_m_axis_tuser) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch exp %h/%b got %h/%b", {e.z, e.y, e.x}, e.nz,
                                 o_m_axis_tdata, o_m_axis_tuser);
                end
            end
            snk_gap = $urandom_range(0, 9);
        end
        if (snk_gap > 0) snk_gap--;
        i_m_axis_tready <= i_rst_n && (snk_gap == 0 || $urandom_range(0, 7) == 0);
    end

    task automatic apb_write(int idx, logic [63:0] val);
        @(posedge i_clk);
        i_psel <= 1'b1; i_penable <= 1'b0; i_pwrite <= 1'b1;
        i_paddr <= PADDR_W'(idx * 8); i_pwdata <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0; i_penable <= 1'b0; i_pwrite <= 1'b0;
        mat_regs[idx] = val;
    endtask

    task automatic push_vtx(logic [31:0] x, y, z, w, logic dv);
        vtx_t v;
        v.x = x; v.y = y; v.z = z; v.w = w; v.dv = dv;
        pending_vtx.push_back(v);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return 32'h0001_0000;
            2: return $urandom_range(0, 40) - 20;
            default: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
        endcase
    endfunction

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'h0;
            default: return {{14{$urandom_range(0, 1) == 1}}, 18'($urandom())};
        endcase
    endfunction

    task automatic run_phase();
        driver_on = 1'b1;
        wait (pending_vtx.size() == 0 && expected_xf.size() == 0 || timed_out);
        driver_on = 1'b0;
        repeat (60) @(posedge i_clk);
    endtask

    task automatic finish_run();
        if (timed_out) $display("[vertex_transform_persp_divide_core] ERROR");
        else if (n_mismatch == 0) $display("[vertex_transform_persp_divide_core] OK");
        else $display("[vertex_transform_persp_divide_core] ERROR");
        $finish;
    endtask

    initial begin
        mat_regs[0] = 64'd65536; mat_regs[1] = 0; mat_regs[2] = 64'h1_0000_0000_0000;
        mat_regs[3] = 0; mat_regs[4] = 0; mat_regs[5] = 64'd65536;
        mat_regs[6] = 0; mat_regs[7] = 64'h1_0000_0000_0000;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // identity matrix: extremes, divide on and off, near-zero w
        push_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1_0000, 1'b0);
        push_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h1_0000, 1'b1);
        push_vtx(32'h2_0000, 32'h3_0000, 32'h4_0000, 32'h0, 1'b1);
        push_vtx(32'h2_0000, 32'h3_0000, 32'h4_0000, 32'd66, 1'b1);
        push_vtx(32'h2_0000, 32'h3_0000, 32'h4_0000, -32'sd66, 1'b1);
        push_vtx(32'h2_0000, 32'h3_0000, 32'h4_0000, 32'd67, 1'b1);
        push_vtx(32'h2_0000, 32'hFFFD_0000, 32'h4_0000, -32'sd67, 1'b1);
        push_vtx(32'h1, 32'h3, 32'h5, 32'h3_0000, 1'b1);
        push_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1);
        push_vtx(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_phase();

        // extreme matrix entries, overflow and half rounding
        for (int i = 0; i < NUM_REGS; i++)
            apb_write(i, (i % 2) ? 64'h8000_0000_7FFF_FFFF : 64'h7FFF_FFFF_8000_0000);
        push_vtx(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
        push_vtx(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        push_vtx(32'h1, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vtx(32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        run_phase();
        for (int i = 0; i < NUM_REGS; i++) apb_write(i, 64'h0000_8000_0000_8000);
        push_vtx(32'h1, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vtx(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        push_vtx(32'h3, 32'h0, 32'h0, 32'h5_0000, 1'b1);
        run_phase();

        for (int ph = 0; ph < 7; ph++) begin
            for (int i = 0; i < NUM_REGS; i++) apb_write(i, {rand_entry(), rand_entry()});
            if (ph == 0) begin
                apb_write(0, {32'h0, 32'h1_0000}); apb_write(2, {32'h1_0000, 32'h0});
            end
            for (int k = 0; k < N_RAND / 7; k++)
                push_vtx(rand_coord(), rand_coord(), rand_coord(),
                         $urandom_range(0, 2) == 0 ? rand_coord() : 32'h1_0000,
                         $urandom_range(0, 3) != 0);
            run_phase();
            if (timed_out) break;
        end
        finish_run();
    end

    initial begin
        wait (timed_out);
        finish_run();
    end
endmodule
